>>> sv/stx_frame_parser_xor_check_core_defines.svh
// Assertion macros shared by the checker files of the frame parser.
`ifndef STX_FRAME_PARSER_XOR_CHECK_CORE_DEFINES_SVH
`define STX_FRAME_PARSER_XOR_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge and idle in reset.
`define STXP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and idle in reset.
`define STXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/stxp_pkg.sv
package stxp_pkg;

    // Field and bus widths.
    localparam int STXP_PAYLOAD_BYTES = 8;
    localparam int BYTE_W             = 8;
    localparam int KIND_W             = 2;
    localparam int PAYLOAD_W          = 64;
    localparam int M_TDATA_W          = BYTE_W + PAYLOAD_W;
    localparam int APB_ADDR_W         = 4;
    localparam int APB_DATA_W         = 32;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] ALIVE_CODE_RST  = 8'd0;
    localparam logic [BYTE_W-1:0] ENABLE_CODE_RST = 8'd1;
    localparam logic [BYTE_W-1:0] STATUS_CODE_RST = 8'd2;

    // Register word index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_START_BYTE,
        REG_ALIVE_CODE,
        REG_ENABLE_CODE,
        REG_STATUS_CODE
    } reg_idx_t;

    // Decoded response kind of a command.
    typedef enum logic [KIND_W-1:0] {
        KIND_ALIVE,
        KIND_ENABLE,
        KIND_STATUS,
        KIND_OTHER
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] alive_code;
        logic [BYTE_W-1:0] enable_code;
        logic [BYTE_W-1:0] status_code;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    command;
        kind_t                response_kind;
        logic [PAYLOAD_W-1:0] payload_bits;
    } result_t;

endpackage

>>> sv/stxp_apb_regs.sv
module stxp_apb_regs
    import stxp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg_o
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg_o   = cfg_reg;

    // Register writes in the access phase of a write transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte  <= START_BYTE_RST;
            cfg_reg.alive_code  <= ALIVE_CODE_RST;
            cfg_reg.enable_code <= ENABLE_CODE_RST;
            cfg_reg.status_code <= STATUS_CODE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START_BYTE:  cfg_reg.start_byte  <= pwdata[BYTE_W-1:0];
                REG_ALIVE_CODE:  cfg_reg.alive_code  <= pwdata[BYTE_W-1:0];
                REG_ENABLE_CODE: cfg_reg.enable_code <= pwdata[BYTE_W-1:0];
                REG_STATUS_CODE: cfg_reg.status_code <= pwdata[BYTE_W-1:0];
            endcase
        end
    end

    // Read data, zero-extended to the bus width.
    always_comb begin
        unique case (reg_idx)
            REG_START_BYTE:  prdata = APB_DATA_W'(cfg_reg.start_byte);
            REG_ALIVE_CODE:  prdata = APB_DATA_W'(cfg_reg.alive_code);
            REG_ENABLE_CODE: prdata = APB_DATA_W'(cfg_reg.enable_code);
            REG_STATUS_CODE: prdata = APB_DATA_W'(cfg_reg.status_code);
        endcase
    end

endmodule

>>> sv/stxp_in_reg.sv
module stxp_in_reg
    import stxp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              take_i,
    output logic              item_valid_o,
    output logic [BYTE_W-1:0] item_byte_o
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    // A new byte may enter when the stage is empty or is emptied this cycle.
    assign s_tready     = !valid_reg || take_i;
    assign item_valid_o = valid_reg;
    assign item_byte_o  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take_i) begin
            valid_reg <= 1'b0;
        end
    end

    // The byte itself needs no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

>>> sv/stxp_frame_fsm.sv
module stxp_frame_fsm
    import stxp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = STXP_PAYLOAD_BYTES
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg_i,
    input  logic              item_valid_i,
    input  logic [BYTE_W-1:0] item_byte_i,
    input  logic              res_ready_i,
    output logic              item_take_o,
    output logic              res_valid_o,
    output result_t           result_o
);

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_PAYLOAD,
        PH_CHECK,
        PH_TRAIL
    } phase_t;

    phase_t            phase_reg,   phase_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [IDX_W-1:0]  count_reg,   count_next;
    logic [BYTE_W-1:0] xor_reg,     xor_next;
    logic [BYTE_W-1:0] store_reg [PAYLOAD_BYTES];
    logic              xor_match;
    kind_t             kind;

    // A matching check byte makes a result and must find room downstream.
    assign xor_match   = (phase_reg == PH_CHECK) && (item_byte_i == xor_reg);
    assign item_take_o = item_valid_i && (!xor_match || res_ready_i);
    assign res_valid_o = item_take_o && xor_match;

    // Next-state logic for one received byte.
    always_comb begin
        phase_next   = phase_reg;
        command_next = command_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        if (item_take_o) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (item_byte_i == cfg_i.start_byte) begin
                        phase_next   = PH_CMD;
                        command_next = '0;
                        count_next   = '0;
                        xor_next     = '0;
                    end
                end
                PH_CMD: begin
                    command_next = item_byte_i;
                    xor_next     = xor_reg ^ item_byte_i;
                    phase_next   = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    xor_next   = xor_reg ^ item_byte_i;
                    count_next = count_reg + IDX_W'(1);
                    if (count_reg == LAST_IDX) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = xor_match ? PH_TRAIL : PH_HUNT;
                end
                // The trailing byte is dropped unchecked; stray codes recover here too.
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            command_reg <= '0;
            count_reg   <= '0;
            xor_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
        end
    end

    // Payload store, written one byte per payload transaction.
    always_ff @(posedge aclk) begin
        if (item_take_o && (phase_reg == PH_PAYLOAD)) begin
            store_reg[count_reg] <= item_byte_i;
        end
    end

    // Command decode; alive wins over enable, enable over status.
    always_comb begin
        priority if (command_reg == cfg_i.alive_code) begin
            kind = KIND_ALIVE;
        end else if (command_reg == cfg_i.enable_code) begin
            kind = KIND_ENABLE;
        end else if (command_reg == cfg_i.status_code) begin
            kind = KIND_STATUS;
        end else begin
            kind = KIND_OTHER;
        end
    end

    assign result_o.command       = command_reg;
    assign result_o.response_kind = kind;

    // Pack the payload, first byte lowest; unused upper bytes stay zero.
    for (genvar i = 0; i < PAYLOAD_W / BYTE_W; i++) begin : g_pack
        if (i < PAYLOAD_BYTES) begin : g_used
            assign result_o.payload_bits[i*BYTE_W +: BYTE_W] = store_reg[i];
        end else begin : g_unused
            assign result_o.payload_bits[i*BYTE_W +: BYTE_W] = '0;
        end
    end

endmodule

>>> sv/stxp_out_reg.sv
module stxp_out_reg
    import stxp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_i,
    input  result_t              result_i,
    output logic                 ready_o,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]    m_tuser
);

    logic    valid_reg;
    result_t result_reg;

    // Room for a result when empty or when the held one leaves this cycle.
    assign ready_o  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {result_reg.payload_bits, result_reg.command};
    assign m_tuser  = result_reg.response_kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_i) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            result_reg <= result_i;
        end
    end

endmodule

>>> sv/stx_frame_parser_xor_check_core.sv
// Channel   | Direction | Payload
// ----------+-----------+------------------------------------------------------
// s_        | in        | s_tdata[7:0] rx_byte
// m_        | out       | m_tdata[7:0] command, [71:8] payload_bits; m_tuser kind
// APB       | in        | registers start_byte, alive, enable, status at 0x0..0xC
//
// One byte per clock is taken unless m_ stalls a result; each byte is held in the
// input register; a result appears on m_ the cycle after its check byte is taken.
// The only loop is the frame state register, updated once per byte.
// Reset (aresetn low, synchronous) empties both stages and returns to hunting.
// A stalled m_ side holds the input stage only when a result is waiting to load.
module stx_frame_parser_xor_check_core
    import stxp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = STXP_PAYLOAD_BYTES
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,    // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // [7:0] command, [71:8] payload_bits
    output logic [KIND_W-1:0]     m_tuser,    // [1:0] response_kind
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t              cfg;
    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    logic              item_take;
    logic              res_valid;
    logic              res_ready;
    result_t           result;

    // Configuration registers.
    stxp_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    // Input register.
    stxp_in_reg u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .take_i       (item_take),
        .item_valid_o (item_valid),
        .item_byte_o  (item_byte)
    );

    // Frame state machine and result build.
    stxp_frame_fsm #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_fsm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_i        (cfg),
        .item_valid_i (item_valid),
        .item_byte_i  (item_byte),
        .res_ready_i  (res_ready),
        .item_take_o  (item_take),
        .res_valid_o  (res_valid),
        .result_o     (result)
    );

    // Result register.
    stxp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (res_valid),
        .result_i (result),
        .ready_o  (res_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> sv/stxp_checker.sv
`include "stx_frame_parser_xor_check_core_defines.svh"

module stxp_checker
    import stxp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [KIND_W-1:0]     m_tuser,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // A stalled result stays valid and unchanged.
    `STXP_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // With no result pending the parser never pushes back on its input.
    `STXP_ASSERT_IMPL(a_s_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

    // A fresh result follows its check byte via the input and result registers.
    `STXP_ASSERT_IMPL(a_m_after_input, $rose(m_tvalid),
        $past(s_tvalid && s_tready, 2), "result without check byte")

    // A register read right after a write returns the written byte.
    `STXP_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready,
        pwrite || (paddr != $past(paddr)) ||
        ((prdata[7:0] == $past(pwdata[7:0])) && (prdata[31:8] == 24'd0)),
        "register readback mismatch")

endmodule

bind stx_frame_parser_xor_check_core stxp_checker u_stxp_checker (.*);

>>> test/tb_stx_frame_parser_xor_check_core.sv
module tb_stx_frame_parser_xor_check_core;
    import stxp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;

    // Parser phases as tracked by the testbench.
    typedef enum logic [2:0] {
        SEEK_START,
        TAKE_CMD,
        TAKE_PAYLOAD,
        TAKE_CHECK,
        SKIP_TRAIL
    } parse_state_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata  = '0;     // [7:0] rx_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // [7:0] command, [71:8] payload_bits
    logic [KIND_W-1:0]     m_tuser;           // [1:0] response_kind
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the registers and of the frame being parsed.
    cfg_t                 cfg;
    parse_state_t         rx_state;
    logic [BYTE_W-1:0]    frame_cmd;
    logic [PAYLOAD_W-1:0] frame_payload;
    logic [3:0]           frame_count;
    logic [BYTE_W-1:0]    frame_xor;

    result_t pending_frames[$];
    int      mismatch_count = 0;
    int      live_bytes     = 0;
    int      stall_cycles   = 0;
    int      src_idle_pct   = 0;
    int      snk_stall_pct  = 0;
    int      hold_req       = 0;
    int      hold_seen      = 0;
    int      hold_left      = 0;

    stx_frame_parser_xor_check_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side ready: random stalls, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic kind_t decode_kind(input logic [BYTE_W-1:0] cmd);
        if (cmd == cfg.alive_code) return KIND_ALIVE;
        if (cmd == cfg.enable_code) return KIND_ENABLE;
        if (cmd == cfg.status_code) return KIND_STATUS;
        return KIND_OTHER;
    endfunction

    // Advance the parser shadow by one received byte and queue any frame it completes.
    function automatic void parse_rx_byte(input logic [BYTE_W-1:0] b);
        if (rx_state != SEEK_START || b == cfg.start_byte) live_bytes++;
        case (rx_state)
            SEEK_START: begin
                if (b == cfg.start_byte) begin
                    frame_cmd     = '0;
                    frame_payload = '0;
                    frame_count   = '0;
                    frame_xor     = '0;
                    rx_state      = TAKE_CMD;
                end
            end
            TAKE_CMD: begin
                frame_cmd = b;
                frame_xor ^= b;
                rx_state  = TAKE_PAYLOAD;
            end
            TAKE_PAYLOAD: begin
                frame_payload[frame_count[2:0] * 8 +: 8] = b;
                frame_xor ^= b;
                frame_count = frame_count + 4'd1;
                if (frame_count >= 4'(STXP_PAYLOAD_BYTES)) rx_state = TAKE_CHECK;
            end
            TAKE_CHECK: begin
                if (b == frame_xor) begin
                    pending_frames.push_back(result_t'{
                        command:       frame_cmd,
                        response_kind: decode_kind(frame_cmd),
                        payload_bits:  frame_payload});
                    rx_state = SKIP_TRAIL;
                end else begin
                    rx_state = SEEK_START;
                end
            end
            default: rx_state = SEEK_START;
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endfunction

    // Compare one result transaction with the oldest pending frame.
    function automatic void check_frame(input logic [M_TDATA_W-1:0] data,
                                        input logic [KIND_W-1:0] kind);
        result_t want;
        if (pending_frames.size() == 0) begin
            report_mismatch("unexpected result, payload", '0, data[M_TDATA_W-1:BYTE_W]);
        end else begin
            want = pending_frames.pop_front();
            if (data[BYTE_W-1:0] !== want.command)
                report_mismatch("command", 64'(want.command), 64'(data[BYTE_W-1:0]));
            if (kind !== want.response_kind)
                report_mismatch("response_kind", 64'(want.response_kind), 64'(kind));
            if (data[M_TDATA_W-1:BYTE_W] !== want.payload_bits)
                report_mismatch("payload_bits", want.payload_bits, data[M_TDATA_W-1:BYTE_W]);
        end
    endfunction

    // Monitor: results, register writes, received bytes and the watchdog.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg          = cfg_t'{START_BYTE_RST, ALIVE_CODE_RST, ENABLE_CODE_RST,
                                  STATUS_CODE_RST};
            rx_state     = SEEK_START;
            frame_cmd    = '0;
            frame_count  = '0;
            frame_xor    = '0;
            stall_cycles = 0;
        end else begin
            if (m_tvalid && m_tready) check_frame(m_tdata, m_tuser);
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_START_BYTE:  cfg.start_byte  = pwdata[BYTE_W-1:0];
                    REG_ALIVE_CODE:  cfg.alive_code  = pwdata[BYTE_W-1:0];
                    REG_ENABLE_CODE: cfg.enable_code = pwdata[BYTE_W-1:0];
                    REG_STATUS_CODE: cfg.status_code = pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) parse_rx_byte(s_tdata);

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_stx_frame_parser_xor_check_core: done, errors");
                $finish;
            end
        end
    end

    // Offer one byte, with random idle cycles before it, and wait until it is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [PAYLOAD_W-1:0] payload,
                              input bit good_check, input logic [BYTE_W-1:0] trail);
        logic [BYTE_W-1:0] sum;
        sum = cmd;
        send_byte(cfg.start_byte);
        send_byte(cmd);
        for (int i = 0; i < STXP_PAYLOAD_BYTES; i++) begin
            send_byte(payload[8*i +: 8]);
            sum ^= payload[8*i +: 8];
        end
        if (!good_check) sum ^= 8'(1 << $urandom_range(7));
        send_byte(sum);
        send_byte(trail);
    endtask

    // Mostly well-formed frames with random content, plus noise and cut-off frames.
    task automatic send_random_frame();
        int                   pick;
        logic [BYTE_W-1:0]    cmd;
        logic [PAYLOAD_W-1:0] payload;
        logic [BYTE_W-1:0]    trail;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end else if (pick < 14) begin
            send_byte(cfg.start_byte);
            send_byte(8'($urandom));
            repeat ($urandom_range(0, STXP_PAYLOAD_BYTES - 1)) send_byte(8'($urandom));
        end else begin
            case ($urandom_range(4))
                0:       cmd = cfg.alive_code;
                1:       cmd = cfg.enable_code;
                2:       cmd = cfg.status_code;
                default: cmd = 8'($urandom);
            endcase
            for (int i = 0; i < STXP_PAYLOAD_BYTES; i++) begin
                case ($urandom_range(9))
                    0:       payload[8*i +: 8] = 8'h00;
                    1:       payload[8*i +: 8] = 8'hFF;
                    default: payload[8*i +: 8] = 8'($urandom);
                endcase
            end
            trail = ($urandom_range(3) == 0) ? cfg.start_byte : 8'($urandom);
            send_frame(cmd, payload, $urandom_range(99) < 85, trail);
        end
    endtask

    task automatic wait_results_drained();
        while (pending_frames.size() != 0) @(posedge aclk);
    endtask

    // Stop offering bytes and let the block settle before touching its registers.
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input reg_idx_t idx, input logic [BYTE_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W - BYTE_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input cfg_t c);
        quiesce();
        write_reg(REG_START_BYTE, c.start_byte);
        write_reg(REG_ALIVE_CODE, c.alive_code);
        write_reg(REG_ENABLE_CODE, c.enable_code);
        write_reg(REG_STATUS_CODE, c.status_code);
    endtask

    // Reset settings: an alive frame whose payload holds the start byte and
    // whose trailing byte is the start byte, then a status frame with a bad check.
    task automatic test_directed_frames();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_frame(8'h00, 64'h00FF_807F_0102_FF00, 1'b1, cfg.start_byte);
        send_frame(8'h02, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00);
        quiesce();
    endtask

    // Coinciding codes: alive wins over enable, enable wins over status.
    task automatic test_code_priority();
        set_config(cfg_t'{start_byte: 8'h00, alive_code: 8'h5A, enable_code: 8'h5A,
                          status_code: 8'h5A});
        send_frame(8'h5A, 64'h0123_4567_89AB_CDEF, 1'b1, 8'hFF);
        quiesce();
        write_reg(REG_ALIVE_CODE, 8'hA5);
        send_frame(8'h5A, 64'hFEDC_BA98_7654_3210, 1'b1, 8'h00);
        quiesce();
        write_reg(REG_ENABLE_CODE, 8'h3C);
        send_frame(8'h5A, 64'h8000_0000_0000_0001, 1'b1, 8'h00);
        send_frame(8'h00, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 8'h00);
        send_frame(8'hA5, 64'h0000_0000_0000_0000, 1'b1, 8'h5A);
        send_frame(8'h3C, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h3C);
        quiesce();
    endtask

    task automatic test_random_traffic(input cfg_t c, input int src_pct, input int snk_pct,
                                       input int n_bytes);
        int first;
        set_config(c);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        first = live_bytes;
        while (live_bytes - first < n_bytes) send_random_frame();
        quiesce();
    endtask

    // Long receiver hold-off while bytes keep coming, so the input side stalls.
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req++;
        repeat (20) send_frame(8'($urandom), {$urandom, $urandom}, 1'b1, 8'($urandom));
        quiesce();
    endtask

    // Sender pauses mid-run until every pending frame has come out.
    task automatic test_drain_pause();
        src_idle_pct  = 17;
        snk_stall_pct = 17;
        repeat (4) send_random_frame();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (4) send_random_frame();
        quiesce();
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_frames();
        test_code_priority();
        test_random_traffic(cfg_t'{8'hFF, 8'h00, 8'hFF, 8'h80}, 0, 0, 270);
        test_random_traffic(cfg_t'{8'h00, 8'hFF, 8'h7F, 8'h01}, 85, 0, 270);
        test_random_traffic(cfg_t'($urandom), 0, 85, 270);
        test_random_traffic(cfg_t'{START_BYTE_RST, ALIVE_CODE_RST, ENABLE_CODE_RST,
                                   STATUS_CODE_RST}, 17, 17, 270);
        test_output_backpressure();
        test_drain_pause();

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_frames.size() == 0) begin
            $display("tb_stx_frame_parser_xor_check_core: done, clean");
        end else begin
            $display("tb_stx_frame_parser_xor_check_core: done, errors");
        end
        $finish;
    end

endmodule
